[rtl/dhbr_pkg.sv]
package dhbr_pkg;

  // Number of buttons watched by the block
  localparam int NUM_BUTTONS = 3;

  // Field widths
  localparam int BTN_W      = 3;
  localparam int LAT_W      = 28;
  localparam int LON_W      = 29;
  localparam int CODE_W     = 2;
  localparam int QUAL_W     = 2;
  localparam int TIME_W     = 32;
  localparam int DEB_W      = 16;
  localparam int HOLD_W     = 16;
  localparam int STALE_W    = 24;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 64;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 2;

  // Register map (word index)
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STALE    = 2'd2;

  // Reset values of the registers
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd50;
  localparam logic [HOLD_W-1:0]  HOLD_RST     = 16'd3000;
  localparam logic [STALE_W-1:0] STALE_RST    = 24'd60000;

  // Position quality codes
  localparam logic [QUAL_W-1:0] QUAL_NONE  = 2'd0;
  localparam logic [QUAL_W-1:0] QUAL_FRESH = 2'd1;
  localparam logic [QUAL_W-1:0] QUAL_STALE = 2'd2;

  // Timing settings shared by all button cells
  typedef struct packed {
    logic [DEB_W-1:0]  settle_ms;
    logic [HOLD_W-1:0] hold_ms;
  } btn_cfg_t;

  // Per-tick strobe into a button cell
  typedef struct packed {
    logic              tick;
    logic              level;
    logic [TIME_W-1:0] now;
  } btn_tick_t;

endpackage

[rtl/dhbr_btn.sv]
module dhbr_btn
  import dhbr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  btn_cfg_t  cfg_i,
  input  btn_tick_t tick_i,
  output logic      fire_o
);

  logic              raw_q, raw_d;
  logic              stable_q, stable_d;
  logic              sent_q, sent_d;
  logic [TIME_W-1:0] chg_q, chg_d;
  logic [TIME_W-1:0] press_q, press_d;

  logic              changed;
  logic [TIME_W-1:0] since_chg;
  logic              stab_upd;
  logic              new_press;
  logic [TIME_W-1:0] since_press;
  logic              sent_pre;

  // Debounce, then hold check, all against the tick's time
  always_comb begin
    changed     = tick_i.level != raw_q;
    since_chg   = changed ? '0 : tick_i.now - chg_q;
    stab_upd    = (since_chg >= TIME_W'(cfg_i.settle_ms)) && (tick_i.level != stable_q);
    stable_d    = stab_upd ? tick_i.level : stable_q;
    new_press   = stab_upd && tick_i.level;
    since_press = new_press ? '0 : tick_i.now - press_q;
    sent_pre    = new_press ? 1'b0 : sent_q;
    fire_o      = tick_i.tick && stable_d && !sent_pre &&
                  (since_press >= TIME_W'(cfg_i.hold_ms));
    raw_d       = tick_i.level;
    chg_d       = changed ? tick_i.now : chg_q;
    press_d     = new_press ? tick_i.now : press_q;
    sent_d      = sent_pre | fire_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      sent_q   <= 1'b0;
      chg_q    <= '0;
      press_q  <= '0;
    end else if (tick_i.tick) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      sent_q   <= sent_d;
      chg_q    <= chg_d;
      press_q  <= press_d;
    end
  end

endmodule

[rtl/debounced_hold_button_reporter_top.sv]
// Debounced hold-button reporter.
// Input stream: one beat per millisecond tick carrying the raw button levels,
// an optional new position fix (tuser flags it) and its coordinates.
// Output stream: one beat per report; tuser holds the button index, tdata the
// quality and position, tlast marks the final report of a tick.
// APB port: debounce time at 0x0, hold time at 0x4, stale age at 0x8; write
// only while the block is idle.
// Reports of an accepted tick are registered in the report buffer, then move into
// the output register one per cycle while the receiver takes them.
// A tick that causes no report leaves s_axis_tready high; a tick that causes
// reports holds the input while the report buffer drains into the output
// register (at most NUM_BUTTONS reports).
// Reset clears the tick counter, all button state, the fix and the output
// valid flag, and loads the register defaults. A stall on m_axis_tready holds
// the current beat; pending reports wait in the buffer, and s_axis_tready
// stays low until the buffer is empty.
module debounced_hold_button_reporter_top
  import dhbr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input tick stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] buttons_pressed, [30:3] fix_lat, [59:31] fix_lon, [63:60] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] fix_valid
  input  logic [0:0]           s_axis_tuser,
  // Report stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] quality, [29:2] report_lat, [58:30] report_lon, [63:59] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status_code
  output logic [CODE_W-1:0]    m_axis_tuser,
  output logic                 m_axis_tlast,
  // Configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  // Registers
  logic [DEB_W-1:0]   deb_q;
  logic [HOLD_W-1:0]  hold_q;
  logic [STALE_W-1:0] stale_q;
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= DEBOUNCE_RST;
      hold_q  <= HOLD_RST;
      stale_q <= STALE_RST;
    end else if (cfg_wr) begin
      if (reg_idx == REG_DEBOUNCE) deb_q   <= pwdata[DEB_W-1:0];
      if (reg_idx == REG_HOLD)     hold_q  <= pwdata[HOLD_W-1:0];
      if (reg_idx == REG_STALE)    stale_q <= pwdata[STALE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DEBOUNCE)   prdata = APB_DW'(deb_q);
    else if (reg_idx == REG_HOLD)  prdata = APB_DW'(hold_q);
    else if (reg_idx == REG_STALE) prdata = APB_DW'(stale_q);
  end

  // Input beat fields
  logic [BTN_W-1:0] in_btn;
  logic             in_fix;
  logic [LAT_W-1:0] in_lat;
  logic [LON_W-1:0] in_lon;
  logic             acc;

  assign in_btn = s_axis_tdata[BTN_W-1:0];
  assign in_lat = s_axis_tdata[BTN_W +: LAT_W];
  assign in_lon = s_axis_tdata[BTN_W+LAT_W +: LON_W];
  assign in_fix = s_axis_tuser[0];
  assign acc    = s_axis_tvalid && s_axis_tready;

  // Time and fix state
  logic [TIME_W-1:0] tick_q;
  logic [TIME_W-1:0] fix_time_q, fix_time_d;
  logic              ever_q, ever_d;
  logic [LAT_W-1:0]  lat_q, lat_d;
  logic [LON_W-1:0]  lon_q, lon_d;
  logic [TIME_W-1:0] fix_age;
  logic [QUAL_W-1:0] qual_d;

  // A new fix is applied before the reports of this tick are built
  always_comb begin
    ever_d     = ever_q | in_fix;
    fix_time_d = in_fix ? tick_q : fix_time_q;
    lat_d      = in_fix ? in_lat : lat_q;
    lon_d      = in_fix ? in_lon : lon_q;
    fix_age    = tick_q - fix_time_d;
    if (!ever_d)                              qual_d = QUAL_NONE;
    else if (fix_age <= TIME_W'(stale_q))     qual_d = QUAL_FRESH;
    else                                      qual_d = QUAL_STALE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      fix_time_q <= '0;
      ever_q     <= 1'b0;
      lat_q      <= '0;
      lon_q      <= '0;
    end else if (acc) begin
      tick_q     <= tick_q + 1'b1;
      fix_time_q <= fix_time_d;
      ever_q     <= ever_d;
      lat_q      <= lat_d;
      lon_q      <= lon_d;
    end
  end

  // Button cells
  btn_cfg_t               btn_cfg;
  logic [NUM_BUTTONS-1:0] fire;

  assign btn_cfg.settle_ms = deb_q;
  assign btn_cfg.hold_ms   = hold_q;

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    btn_tick_t bt;
    assign bt.tick  = acc;
    assign bt.now   = tick_q;
    if (g < BTN_W) begin : g_lvl
      assign bt.level = in_btn[g];
    end else begin : g_zero
      assign bt.level = 1'b0;
    end
    dhbr_btn u_btn (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cfg_i  (btn_cfg),
      .tick_i (bt),
      .fire_o (fire[g])
    );
  end

  // Report buffer: pending buttons of one tick with their shared snapshot
  logic [NUM_BUTTONS-1:0] pend_q, pend_d;
  logic [QUAL_W-1:0]      pqual_q;
  logic [LAT_W-1:0]       plat_q;
  logic [LON_W-1:0]       plon_q;

  // Output register
  logic              mvalid_q, mvalid_d;
  logic              mlast_q, mlast_d;
  logic [CODE_W-1:0] mcode_q, mcode_d;
  logic [QUAL_W-1:0] mqual_q;
  logic [LAT_W-1:0]  mlat_q;
  logic [LON_W-1:0]  mlon_q;
  logic              take;
  logic              load;
  logic [NUM_BUTTONS-1:0] sel_oh;

  assign s_axis_tready = (pend_q == '0);

  // Pick the lowest pending button for the next beat
  always_comb begin
    logic found;
    found    = 1'b0;
    sel_oh   = '0;
    mcode_d  = mcode_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (pend_q[i] && !found) begin
        found     = 1'b1;
        sel_oh[i] = 1'b1;
        mcode_d   = CODE_W'(i);
      end
    end
    take     = !mvalid_q || m_axis_tready;
    load     = take && found;
    mlast_d  = ((pend_q & ~sel_oh) == '0);
    mvalid_d = take ? found : mvalid_q;
    if (acc)       pend_d = fire;
    else if (load) pend_d = pend_q & ~sel_oh;
    else           pend_d = pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pqual_q <= qual_d;
      plat_q  <= ever_d ? lat_d : '0;
      plon_q  <= ever_d ? lon_d : '0;
    end
    if (load) begin
      mcode_q <= mcode_d;
      mlast_q <= mlast_d;
      mqual_q <= pqual_q;
      mlat_q  <= plat_q;
      mlon_q  <= plon_q;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tuser  = mcode_q;
  assign m_axis_tlast  = mlast_q;
  assign m_axis_tdata  = {{(M_TDATA_W-QUAL_W-LAT_W-LON_W){1'b0}}, mlon_q, mlat_q, mqual_q};

endmodule

[bench/tb_top.sv]
module tb_top;
  import dhbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 decodes to no register; writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SHOWN_ERRORS  = 10;

  // One report as it leaves the block
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [QUAL_W-1:0] qual;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    logic              last;
  } report_t;

  // Mirrors the button/fix state and queues the reports each tick should produce
  class report_board;
    logic [DEB_W-1:0]       settle_ms;
    logic [HOLD_W-1:0]      hold_ms;
    logic [STALE_W-1:0]     stale_ms;
    logic [TIME_W-1:0]      now_ms;
    logic [NUM_BUTTONS-1:0] raw_q;
    logic [NUM_BUTTONS-1:0] stable_q;
    logic [NUM_BUTTONS-1:0] sent_q;
    logic [TIME_W-1:0]      change_ms [NUM_BUTTONS];
    logic [TIME_W-1:0]      press_ms [NUM_BUTTONS];
    logic                   have_fix;
    logic [TIME_W-1:0]      fix_ms;
    logic [LAT_W-1:0]       lat_q;
    logic [LON_W-1:0]       lon_q;
    report_t                due_reports [$];
    int                     errors;

    function new();
      settle_ms   = DEBOUNCE_RST;
      hold_ms     = HOLD_RST;
      stale_ms    = STALE_RST;
      now_ms      = '0;
      raw_q       = '0;
      stable_q    = '0;
      sent_q      = '0;
      have_fix    = 1'b0;
      fix_ms      = '0;
      lat_q       = '0;
      lon_q       = '0;
      errors      = 0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_ms[i] = '0;
        press_ms[i]  = '0;
      end
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
      case (idx)
        REG_DEBOUNCE: settle_ms   = data[DEB_W-1:0];
        REG_HOLD:     hold_ms     = data[HOLD_W-1:0];
        REG_STALE:    stale_ms    = data[STALE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DW-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_DEBOUNCE: return APB_DW'(settle_ms);
        REG_HOLD:     return APB_DW'(hold_ms);
        REG_STALE:    return APB_DW'(stale_ms);
        default:      return '0;
      endcase
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // One millisecond tick: store the fix, debounce each button, queue reports
    function void take_tick(logic [BTN_W-1:0] btn, logic fix, logic [LAT_W-1:0] lat,
                            logic [LON_W-1:0] lon);
      report_t batch [NUM_BUTTONS];
      int      n;
      logic    lvl;
      n = 0;
      if (fix) begin
        lat_q    = lat;
        lon_q    = lon;
        fix_ms   = now_ms;
        have_fix = 1'b1;
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        lvl = btn[i];
        if (lvl != raw_q[i]) begin
          raw_q[i]     = lvl;
          change_ms[i] = now_ms;
        end
        if (now_ms - change_ms[i] >= TIME_W'(settle_ms) && lvl != stable_q[i]) begin
          stable_q[i] = lvl;
          if (lvl) begin
            press_ms[i] = now_ms;
            sent_q[i]   = 1'b0;
          end
        end
        if (stable_q[i] && !sent_q[i] && now_ms - press_ms[i] >= TIME_W'(hold_ms)) begin
          batch[n] = '{code: CODE_W'(i), qual: QUAL_NONE, lat: '0, lon: '0, last: 1'b0};
          if (have_fix) begin
            batch[n].qual = (now_ms - fix_ms <= TIME_W'(stale_ms)) ? QUAL_FRESH : QUAL_STALE;
            batch[n].lat  = lat_q;
            batch[n].lon  = lon_q;
          end
          sent_q[i] = 1'b1;
          n++;
        end
      end
      if (n > 0) batch[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) due_reports.push_back(batch[k]);
      now_ms = now_ms + 1'b1;
    endfunction

    function void match_report(report_t got);
      report_t want;
      if (due_reports.size() == 0) begin
        flag("report with none due", '0, 64'(got));
        return;
      end
      want = due_reports.pop_front();
      if (got.code != want.code) flag("status_code", 64'(want.code), 64'(got.code));
      if (got.qual != want.qual) flag("quality", 64'(want.qual), 64'(got.qual));
      if (got.lat != want.lat) flag("report_lat", 64'(want.lat), 64'(got.lat));
      if (got.lon != want.lon) flag("report_lon", 64'(want.lon), 64'(got.lon));
      if (got.last != want.last) flag("last_report", 64'(want.last), 64'(got.last));
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [0:0]           s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [CODE_W-1:0]    m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [APB_AW-1:0]    paddr         = '0;
  logic [APB_DW-1:0]    pwdata        = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // No idling on either side while set
  logic                 calm          = 1'b0;
  logic [BTN_W-1:0]     held_btn      = '0;
  int                   held_left     = 0;
  int unsigned          cycles        = 0;

  report_board board = new();

  debounced_hold_button_reporter_top dut (.*);

  initial forever #2 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 28);
  end

  // Beat monitor: predict on accepted ticks, check accepted reports
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.take_tick(s_axis_tdata[BTN_W-1:0], s_axis_tuser[0],
                        s_axis_tdata[BTN_W +: LAT_W], s_axis_tdata[BTN_W+LAT_W +: LON_W]);
      if (m_axis_tvalid && m_axis_tready)
        board.match_report('{code: m_axis_tuser, qual: m_axis_tdata[QUAL_W-1:0],
                             lat: m_axis_tdata[QUAL_W +: LAT_W],
                             lon: m_axis_tdata[QUAL_W+LAT_W +: LON_W],
                             last: m_axis_tlast});
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apb_check(input logic [REG_IDX_W-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== board.reg_value(idx))
      board.flag("register read", 64'(board.reg_value(idx)), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop tvalid, wait for every due report, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Reprogram all timing registers; upper junk bits must be masked off
  task automatic program_regs(input int deb, input int hold, input int stale);
    logic [APB_DW-1:0] junk;
    junk = $urandom;
    settle();
    apb_write(REG_DEBOUNCE, {junk[31:16], DEB_W'(deb)});
    apb_write(REG_HOLD, {junk[15:0], HOLD_W'(hold)});
    apb_write(REG_STALE, {junk[7:0], STALE_W'(stale)});
    apb_write(REG_SPARE, junk);
    apb_check(REG_DEBOUNCE);
    apb_check(REG_HOLD);
    apb_check(REG_STALE);
  endtask

  task automatic send_tick(input logic [BTN_W-1:0] btn, input logic fix,
                           input logic [LAT_W-1:0] lat, input logic [LON_W-1:0] lon);
    if (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-BTN_W-LAT_W-LON_W){1'b0}}, lon, lat, btn};
    s_axis_tuser  <= fix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Button patterns held for random runs, with occasional single-tick bounce
  task automatic random_ticks(input int count, input int max_run);
    logic [BTN_W-1:0] btn;
    logic             fix;
    logic [31:0]      bits;
    int               lat_v;
    int               lon_v;
    int               flip;
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    for (int k = 0; k < count; k++) begin
      if (held_left == 0) begin
        held_btn  = BTN_W'($urandom_range(7));
        held_left = $urandom_range(1, max_run);
      end
      held_left--;
      btn = held_btn;
      if ($urandom_range(99) < 12) begin
        flip      = $urandom_range(BTN_W-1);
        btn[flip] = ~btn[flip];
      end
      fix = ($urandom_range(99) < 15);
      if ($urandom_range(9) == 0) begin
        // raw bit patterns, out of range included
        bits = $urandom;
        lat  = bits[LAT_W-1:0];
        bits = $urandom;
        lon  = bits[LON_W-1:0];
      end else begin
        lat_v = int'($urandom_range(180000000)) - 90000000;
        lon_v = int'($urandom_range(360000000)) - 180000000;
        lat   = lat_v[LAT_W-1:0];
        lon   = lon_v[LON_W-1:0];
      end
      send_tick(btn, fix, lat, lon);
    end
  endtask

  initial begin
    static logic [BTN_W-1:0] bounce_seq [17] = '{3'd1, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
                                                 3'd1, 3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2,
                                                 3'd0, 3'd0, 3'd0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero debounce, zero hold, zero stale age: reports land in the press tick
    program_regs(0, 0, 0);
    send_tick(3'b000, 1'b0, '0, '0);
    send_tick(3'b001, 1'b0, '0, '0);                       // never fixed
    send_tick(3'b011, 1'b1, LAT_W'(90000000), LON_W'(-180000000));  // fresh
    send_tick(3'b111, 1'b0, '0, '0);                       // one tick old: stale
    send_tick(3'b000, 1'b0, '0, '0);
    send_tick(3'b111, 1'b1, LAT_W'(-90000000), LON_W'(180000000));  // all three
    send_tick(3'b000, 1'b1, {1'b0, {(LAT_W-1){1'b1}}}, {1'b1, {(LON_W-1){1'b0}}});
    send_tick(3'b101, 1'b1, {1'b1, {(LAT_W-1){1'b0}}}, {1'b0, {(LON_W-1){1'b1}}});
    send_tick(3'b000, 1'b1, '0, '0);
    send_tick(3'b010, 1'b0, '1, '1);                       // coords without fix flag

    // Bounce, a held press, and a press released before the hold time
    program_regs(2, 3, 65535);
    foreach (bounce_seq[k]) send_tick(bounce_seq[k], 1'b0, '0, '0);

    program_regs(1, 2, 5);
    random_ticks(70, 8);
    program_regs(0, 0, 16777215);
    random_ticks(50, 4);
    calm = 1'b1;
    program_regs(3, 6, 20);
    random_ticks(90, 14);
    calm = 1'b0;
    program_regs(2, 4, 0);
    random_ticks(60, 10);
    program_regs(65535, 65535, 16777215);
    random_ticks(30, 10);
    program_regs(5, 1, 40);
    random_ticks(80, 12);

    settle();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dhbr_pkg.sv
rtl/dhbr_btn.sv
rtl/debounced_hold_button_reporter_top.sv
bench/tb_top.sv
